// File: rtl/swfl_pkg.sv
package swfl_pkg;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_MSG   = 2'd1;
	localparam logic [1:0] OP_CMD   = 2'd2;
	localparam logic [1:0] OP_OTHER = 2'd3;

	// verdict codes
	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_FLOOD  = 2'd1;
	localparam logic [1:0] VERDICT_CLOSED = 2'd2;
	localparam logic [1:0] VERDICT_IDLE   = 2'd3;

	// register indexes, byte address is 4 * index
	localparam logic [2:0] REG_MSG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_CMD_ENABLE    = 3'd1;
	localparam logic [2:0] REG_MSG_WINDOW    = 3'd2;
	localparam logic [2:0] REG_CMD_WINDOW    = 3'd3;
	localparam logic [2:0] REG_MAX_MSG_CHARS = 3'd4;
	localparam logic [2:0] REG_MAX_MSG_COUNT = 3'd5;
	localparam logic [2:0] REG_MAX_CMD_COUNT = 3'd6;
	localparam logic [2:0] REG_MAX_IDLE      = 3'd7;

	localparam int SIZE_W   = 32;
	localparam int COUNT_W  = 20;
	localparam int WINLEN_W = 5;

	localparam logic [SIZE_W-1:0]  SIZE_TOP  = '1;
	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

endpackage

// File: rtl/sliding_window_flood_limiter.sv
// an accepted item waits in the input stage until its verdict is registered at the output
// throughput: one item per cycle unless a held verdict waits on result_ready; the running
//   total of each window takes one add or subtract per item; oldest bucket read from a single port
// reset: clears configuration, totals, occupancy, tick and activity counters and the
//   closed flag at once; the bucket stores are not cleared and need no clearing pass
module sliding_window_flood_limiter
	import swfl_pkg::*;
#(
	parameter int MAX_BUCKETS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] msg_length,
	input  logic        exempt,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  verdict
);

	// no window can span more buckets than the length registers can name
	localparam int WIN_MAX     = (1 << WINLEN_W) - 1;
	localparam int STORE_DEPTH = (MAX_BUCKETS < WIN_MAX) ? MAX_BUCKETS : WIN_MAX;
	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int OCC_W = $clog2(MAX_BUCKETS + 1);
	localparam int SUM_W = OCC_W + 1;
	localparam int CMP_W = ((OCC_W > WINLEN_W) ? OCC_W : WINLEN_W) + 1;
	localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(STORE_DEPTH);
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BUCKETS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

	// configuration
	logic                msg_enable_q;
	logic                cmd_enable_q;
	logic [WINLEN_W-1:0] msg_window_q;
	logic [WINLEN_W-1:0] cmd_window_q;
	logic [30:0]         max_msg_chars_q;
	logic [COUNT_W-1:0]  max_msg_count_q;
	logic [COUNT_W-1:0]  max_cmd_count_q;
	logic [30:0]         max_idle_q;

	// bucket stores; the front bucket lives in the accumulators until it is pushed back
	logic [SIZE_W-1:0]  size_mem  [STORE_DEPTH];
	logic [COUNT_W-1:0] mcnt_mem  [STORE_DEPTH];
	logic [COUNT_W-1:0] ccnt_mem  [STORE_DEPTH];

	logic [OCC_W-1:0]   msg_occ_q,   cmd_occ_q;
	logic [IDX_W-1:0]   msg_front_q, cmd_front_q;
	logic [SIZE_W-1:0]  size_acc_q;
	logic [COUNT_W-1:0] mcnt_acc_q,  ccnt_acc_q;
	logic [SIZE_W-1:0]  size_total_q;
	logic [COUNT_W-1:0] mcnt_total_q, ccnt_total_q;
	logic [31:0]        tick_now_q, last_activity_q;
	logic               closed_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  operation_s1;
	logic [15:0] msg_length_s1;
	logic        exempt_s1;

	logic        result_valid_q;
	logic [1:0]  verdict_q;

	logic fire;
	logic cfg_write;

	logic [OCC_W-1:0]   n_msg_occ,   n_cmd_occ;
	logic [IDX_W-1:0]   n_msg_front, n_cmd_front;
	logic [SIZE_W-1:0]  n_size_acc;
	logic [COUNT_W-1:0] n_mcnt_acc,  n_ccnt_acc;
	logic [SIZE_W-1:0]  n_size_total;
	logic [COUNT_W-1:0] n_mcnt_total, n_ccnt_total;
	logic [31:0]        n_tick_now, n_last_activity;
	logic               n_closed;
	logic [1:0]         n_verdict;
	logic               msg_push, cmd_push;

	logic [CMP_W-1:0]   msg_lim, cmd_lim, msg_win_ext, cmd_win_ext;
	logic [SUM_W-1:0]   msg_old_sum, cmd_old_sum;
	logic [IDX_W-1:0]   msg_old_idx, cmd_old_idx;
	logic [SIZE_W-1:0]  old_size;
	logic [COUNT_W-1:0] old_mcnt, old_ccnt;
	logic [SIZE_W-1:0]  size_base;
	logic [COUNT_W-1:0] mcnt_base, ccnt_base;
	logic [SIZE_W:0]    size_sum;
	logic [SIZE_W-1:0]  size_add;
	logic [31:0]        idle_ticks;

	assign fire       = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || fire;
	assign result_valid = result_valid_q;
	assign verdict    = verdict_q;
	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite;

	// window limits clipped to the store depth
	assign msg_win_ext = CMP_W'(msg_window_q);
	assign cmd_win_ext = CMP_W'(cmd_window_q);
	assign msg_lim = (msg_win_ext > MAX_CMP) ? MAX_CMP : msg_win_ext;
	assign cmd_lim = (cmd_win_ext > MAX_CMP) ? MAX_CMP : cmd_win_ext;

	// oldest bucket index, front + occupancy - 1 modulo depth
	assign msg_old_sum = SUM_W'(msg_front_q) + SUM_W'(msg_occ_q) - 1'b1;
	assign cmd_old_sum = SUM_W'(cmd_front_q) + SUM_W'(cmd_occ_q) - 1'b1;
	assign msg_old_idx = (msg_old_sum >= MAX_SUM) ? IDX_W'(msg_old_sum - MAX_SUM)
		: IDX_W'(msg_old_sum);
	assign cmd_old_idx = (cmd_old_sum >= MAX_SUM) ? IDX_W'(cmd_old_sum - MAX_SUM)
		: IDX_W'(cmd_old_sum);

	// with a single bucket the oldest one is the front accumulator
	assign old_size = (msg_occ_q == OCC_W'(1)) ? size_acc_q : size_mem[msg_old_idx];
	assign old_mcnt = (msg_occ_q == OCC_W'(1)) ? mcnt_acc_q : mcnt_mem[msg_old_idx];
	assign old_ccnt = (cmd_occ_q == OCC_W'(1)) ? ccnt_acc_q : ccnt_mem[cmd_old_idx];

	// an empty window opens a zero front bucket on use
	assign size_base = (msg_occ_q == '0) ? '0 : size_acc_q;
	assign mcnt_base = (msg_occ_q == '0) ? '0 : mcnt_acc_q;
	assign ccnt_base = (cmd_occ_q == '0) ? '0 : ccnt_acc_q;

	assign size_sum   = {1'b0, size_total_q} + (SIZE_W + 1)'(msg_length_s1);
	assign size_add   = size_sum[SIZE_W] ? (SIZE_TOP - size_total_q) : SIZE_W'(msg_length_s1);
	assign idle_ticks = tick_now_q - last_activity_q;

	always_comb begin
		n_msg_occ       = msg_occ_q;
		n_cmd_occ       = cmd_occ_q;
		n_msg_front     = msg_front_q;
		n_cmd_front     = cmd_front_q;
		n_size_acc      = size_acc_q;
		n_mcnt_acc      = mcnt_acc_q;
		n_ccnt_acc      = ccnt_acc_q;
		n_size_total    = size_total_q;
		n_mcnt_total    = mcnt_total_q;
		n_ccnt_total    = ccnt_total_q;
		n_tick_now      = tick_now_q;
		n_last_activity = last_activity_q;
		n_closed        = closed_q;
		n_verdict       = VERDICT_ACCEPT;
		msg_push        = 1'b0;
		cmd_push        = 1'b0;

		if (operation_s1 == OP_TICK) begin
			if (msg_enable_q) begin
				if (CMP_W'(msg_occ_q) + 1'b1 > msg_lim) begin
					if (msg_occ_q != '0) begin
						n_size_total = size_total_q - old_size;
						n_mcnt_total = mcnt_total_q - old_mcnt;
						msg_push = 1'b1;
					end
				end else begin
					n_msg_occ = msg_occ_q + 1'b1;
					msg_push = 1'b1;
				end
			end
			if (msg_push) begin
				n_msg_front = (msg_front_q == '0) ? LAST_IDX : msg_front_q - 1'b1;
				n_size_acc  = '0;
				n_mcnt_acc  = '0;
			end
			if (cmd_enable_q) begin
				if (CMP_W'(cmd_occ_q) + 1'b1 > cmd_lim) begin
					if (cmd_occ_q != '0) begin
						n_ccnt_total = ccnt_total_q - old_ccnt;
						cmd_push = 1'b1;
					end
				end else begin
					n_cmd_occ = cmd_occ_q + 1'b1;
					cmd_push = 1'b1;
				end
			end
			if (cmd_push) begin
				n_cmd_front = (cmd_front_q == '0) ? LAST_IDX : cmd_front_q - 1'b1;
				n_ccnt_acc  = '0;
			end
			if (!closed_q && idle_ticks > {1'b0, max_idle_q}) begin
				n_closed  = 1'b1;
				n_verdict = VERDICT_IDLE;
			end
			n_tick_now = tick_now_q + 1'b1;
		end else if (closed_q) begin
			n_verdict = VERDICT_CLOSED;
		end else begin
			n_last_activity = tick_now_q;
			if (operation_s1 == OP_MSG && msg_enable_q) begin
				if (msg_occ_q == '0) begin
					n_msg_occ = OCC_W'(1);
				end
				n_size_acc   = size_base + size_add;
				n_size_total = size_sum[SIZE_W] ? SIZE_TOP : SIZE_W'(size_sum);
				if (mcnt_total_q != COUNT_TOP) begin
					n_mcnt_acc   = mcnt_base + 1'b1;
					n_mcnt_total = mcnt_total_q + 1'b1;
				end else begin
					n_mcnt_acc   = mcnt_base;
				end
				if (n_size_total > {1'b0, max_msg_chars_q} || n_mcnt_total > max_msg_count_q) begin
					n_verdict = VERDICT_FLOOD;
				end
			end else if (operation_s1 == OP_CMD && cmd_enable_q) begin
				if (cmd_occ_q == '0) begin
					n_cmd_occ = OCC_W'(1);
				end
				if (!exempt_s1 && ccnt_total_q != COUNT_TOP) begin
					n_ccnt_acc   = ccnt_base + 1'b1;
					n_ccnt_total = ccnt_total_q + 1'b1;
				end else begin
					n_ccnt_acc   = ccnt_base;
				end
				if (n_ccnt_total > max_cmd_count_q) begin
					n_verdict = VERDICT_FLOOD;
				end
			end
		end
	end

	// front accumulator goes back into the store when a new front is pushed
	always_ff @(posedge clk) begin
		if (fire && msg_push) begin
			size_mem[msg_front_q] <= size_acc_q;
			mcnt_mem[msg_front_q] <= mcnt_acc_q;
		end
		if (fire && cmd_push) begin
			ccnt_mem[cmd_front_q] <= ccnt_acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			operation_s1  <= operation;
			msg_length_s1 <= msg_length;
			exempt_s1     <= exempt;
		end
		if (fire) begin
			verdict_q <= n_verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			result_valid_q  <= 1'b0;
			msg_occ_q       <= '0;
			cmd_occ_q       <= '0;
			msg_front_q     <= '0;
			cmd_front_q     <= '0;
			size_acc_q      <= '0;
			mcnt_acc_q      <= '0;
			ccnt_acc_q      <= '0;
			size_total_q    <= '0;
			mcnt_total_q    <= '0;
			ccnt_total_q    <= '0;
			tick_now_q      <= '0;
			last_activity_q <= '0;
			closed_q        <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (fire) begin
				msg_occ_q       <= n_msg_occ;
				cmd_occ_q       <= n_cmd_occ;
				msg_front_q     <= n_msg_front;
				cmd_front_q     <= n_cmd_front;
				size_acc_q      <= n_size_acc;
				mcnt_acc_q      <= n_mcnt_acc;
				ccnt_acc_q      <= n_ccnt_acc;
				size_total_q    <= n_size_total;
				mcnt_total_q    <= n_mcnt_total;
				ccnt_total_q    <= n_ccnt_total;
				tick_now_q      <= n_tick_now;
				last_activity_q <= n_last_activity;
				closed_q        <= n_closed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_enable_q    <= 1'b0;
			cmd_enable_q    <= 1'b0;
			msg_window_q    <= '0;
			cmd_window_q    <= '0;
			max_msg_chars_q <= '0;
			max_msg_count_q <= '0;
			max_cmd_count_q <= '0;
			max_idle_q      <= '0;
		end else if (cfg_write) begin
			case (paddr[4:2])
				REG_MSG_ENABLE:    msg_enable_q    <= pwdata[0];
				REG_CMD_ENABLE:    cmd_enable_q    <= pwdata[0];
				REG_MSG_WINDOW:    msg_window_q    <= pwdata[WINLEN_W-1:0];
				REG_CMD_WINDOW:    cmd_window_q    <= pwdata[WINLEN_W-1:0];
				REG_MAX_MSG_CHARS: max_msg_chars_q <= pwdata[30:0];
				REG_MAX_MSG_COUNT: max_msg_count_q <= pwdata[COUNT_W-1:0];
				REG_MAX_CMD_COUNT: max_cmd_count_q <= pwdata[COUNT_W-1:0];
				REG_MAX_IDLE:      max_idle_q      <= pwdata[30:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MSG_ENABLE:    prdata = 32'(msg_enable_q);
			REG_CMD_ENABLE:    prdata = 32'(cmd_enable_q);
			REG_MSG_WINDOW:    prdata = 32'(msg_window_q);
			REG_CMD_WINDOW:    prdata = 32'(cmd_window_q);
			REG_MAX_MSG_CHARS: prdata = 32'(max_msg_chars_q);
			REG_MAX_MSG_COUNT: prdata = 32'(max_msg_count_q);
			REG_MAX_CMD_COUNT: prdata = 32'(max_cmd_count_q);
			REG_MAX_IDLE:      prdata = 32'(max_idle_q);
			default:           prdata = '0;
		endcase
	end

endmodule

// File: tb/sv/tb_sliding_window_flood_limiter.sv
`timescale 1ns / 1ps

module tb_sliding_window_flood_limiter;
	import swfl_pkg::*;

	localparam int NUM_BUCKETS   = 16;
	localparam int CYCLE_LIMIT   = 60000;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_PCT      = 29;
	localparam int REPORT_MAX    = 10;
	localparam int PHASE_ITEMS   = 50;
	localparam int FLOOD_BURST   = 20;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  operation;
	logic [15:0] msg_length;
	logic        exempt;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  verdict;

	sliding_window_flood_limiter #(
		.MAX_BUCKETS(NUM_BUCKETS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.msg_length(msg_length),
		.exempt(exempt),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.verdict(verdict)
	);

	// one row of the directed script: a register write or an item
	typedef struct {
		bit          is_reg;
		logic [2:0]  reg_idx;
		logic [31:0] value;
		logic [1:0]  op;
		logic        ex;
		bit          typed;
		logic [1:0]  want;
	} step_t;

	step_t       script[$];
	logic [1:0]  verdicts_due[$];
	int          fail_count;
	int          cycle_count;
	bit          calm;

	// limiter copy: windows, totals, activity
	logic [SIZE_W-1:0]  size_bkt[NUM_BUCKETS];
	logic [COUNT_W-1:0] msg_cnt_bkt[NUM_BUCKETS];
	logic [COUNT_W-1:0] cmd_cnt_bkt[NUM_BUCKETS];
	int unsigned        msg_fill, cmd_fill, msg_head, cmd_head;
	logic [SIZE_W-1:0]  size_sum;
	logic [COUNT_W-1:0] msg_cnt_sum, cmd_cnt_sum;
	logic [31:0]        tick_cnt, last_seen;
	bit                 session_shut;

	// register copies
	bit                  msg_on, cmd_on;
	logic [WINLEN_W-1:0] msg_win, cmd_win;
	logic [30:0]         chars_cap, idle_cap;
	logic [COUNT_W-1:0]  msg_cap, cmd_cap;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sliding_window_flood_limiter verification failed");
			$finish;
		end
	end

	task automatic note_failure(input string what, input logic [1:0] want, input logic [1:0] got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s: expected verdict %0d, got %0d", $realtime, what, want, got);
	endtask

	// verdict checker with random backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (verdicts_due.size() == 0)
					note_failure("verdict with no item pending", 2'bxx, verdict);
				else if (verdict !== verdicts_due[0])
					note_failure("verdict mismatch", verdicts_due.pop_front(), verdict);
				else
					void'(verdicts_due.pop_front());
			end
			result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic logic [31:0] clipped_add(logic [31:0] sum, logic [31:0] add,
		logic [31:0] top);
		return (add > top - sum) ? top - sum : add;
	endfunction

	function automatic logic [1:0] next_verdict(logic [1:0] op, logic [15:0] len, logic ex);
		logic [1:0]  v;
		int unsigned span;
		int unsigned old;
		logic [31:0] a;
		v = VERDICT_ACCEPT;
		if (op == OP_TICK) begin
			// a window longer than the store acts as the full store
			span = (msg_win > NUM_BUCKETS) ? NUM_BUCKETS : msg_win;
			if (msg_on && (msg_fill < span || msg_fill != 0)) begin
				if (msg_fill >= span) begin
					old = (msg_head + msg_fill - 1) % NUM_BUCKETS;
					size_sum = size_sum - size_bkt[old];
					msg_cnt_sum = msg_cnt_sum - msg_cnt_bkt[old];
				end else begin
					msg_fill++;
				end
				msg_head = (msg_head + NUM_BUCKETS - 1) % NUM_BUCKETS;
				size_bkt[msg_head] = '0;
				msg_cnt_bkt[msg_head] = '0;
			end
			span = (cmd_win > NUM_BUCKETS) ? NUM_BUCKETS : cmd_win;
			if (cmd_on && (cmd_fill < span || cmd_fill != 0)) begin
				if (cmd_fill >= span) begin
					old = (cmd_head + cmd_fill - 1) % NUM_BUCKETS;
					cmd_cnt_sum = cmd_cnt_sum - cmd_cnt_bkt[old];
				end else begin
					cmd_fill++;
				end
				cmd_head = (cmd_head + NUM_BUCKETS - 1) % NUM_BUCKETS;
				cmd_cnt_bkt[cmd_head] = '0;
			end
			if (!session_shut && (tick_cnt - last_seen) > idle_cap) begin
				session_shut = 1'b1;
				v = VERDICT_IDLE;
			end
			tick_cnt = tick_cnt + 1;
		end else if (session_shut) begin
			v = VERDICT_CLOSED;
		end else begin
			last_seen = tick_cnt;
			if (op == OP_MSG && msg_on) begin
				if (msg_fill == 0) begin
					msg_fill = 1;
					size_bkt[msg_head] = '0;
					msg_cnt_bkt[msg_head] = '0;
				end
				a = clipped_add(size_sum, {16'd0, len}, SIZE_TOP);
				size_bkt[msg_head] = size_bkt[msg_head] + a;
				size_sum = size_sum + a;
				a = clipped_add({12'd0, msg_cnt_sum}, 32'd1, {12'd0, COUNT_TOP});
				msg_cnt_bkt[msg_head] = msg_cnt_bkt[msg_head] + a[COUNT_W-1:0];
				msg_cnt_sum = msg_cnt_sum + a[COUNT_W-1:0];
				if (size_sum > chars_cap || msg_cnt_sum > msg_cap)
					v = VERDICT_FLOOD;
			end else if (op == OP_CMD && cmd_on) begin
				if (cmd_fill == 0) begin
					cmd_fill = 1;
					cmd_cnt_bkt[cmd_head] = '0;
				end
				if (!ex) begin
					a = clipped_add({12'd0, cmd_cnt_sum}, 32'd1, {12'd0, COUNT_TOP});
					cmd_cnt_bkt[cmd_head] = cmd_cnt_bkt[cmd_head] + a[COUNT_W-1:0];
					cmd_cnt_sum = cmd_cnt_sum + a[COUNT_W-1:0];
				end
				if (cmd_cnt_sum > cmd_cap)
					v = VERDICT_FLOOD;
			end
		end
		return v;
	endfunction

	task automatic offer_item(input logic [1:0] op, input logic [15:0] len, input logic ex,
		input bit typed, input logic [1:0] want);
		logic [1:0] model_v;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		item_valid <= 1'b1;
		operation <= op;
		msg_length <= len;
		exempt <= ex;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		model_v = next_verdict(op, len, ex);
		verdicts_due.push_back(typed ? want : model_v);
	endtask

	task automatic offer_random(input int tick_pct);
		logic [1:0]  op;
		logic [15:0] len;
		if ($urandom_range(99) < tick_pct)
			op = OP_TICK;
		else
			op = 2'($urandom_range(1, 3));
		case ($urandom_range(9))
			0: len = 16'd0;
			1: len = 16'hFFFF;
			2: len = 16'($urandom);
			default: len = 16'($urandom_range(0, 300));
		endcase
		offer_item(op, len, 1'($urandom_range(1)), 1'b0, VERDICT_ACCEPT);
	endtask

	// stop the sender and let every verdict come back
	task automatic drain_items();
		item_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MSG_ENABLE:    msg_on = val[0];
			REG_CMD_ENABLE:    cmd_on = val[0];
			REG_MSG_WINDOW:    msg_win = val[WINLEN_W-1:0];
			REG_CMD_WINDOW:    cmd_win = val[WINLEN_W-1:0];
			REG_MAX_MSG_CHARS: chars_cap = val[30:0];
			REG_MAX_MSG_COUNT: msg_cap = val[COUNT_W-1:0];
			REG_MAX_CMD_COUNT: cmd_cap = val[COUNT_W-1:0];
			REG_MAX_IDLE:      idle_cap = val[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_limits(input bit me, input bit ce, input logic [4:0] mw,
		input logic [4:0] cw, input logic [30:0] chars, input logic [19:0] mc,
		input logic [19:0] cc, input logic [30:0] idle);
		drain_items();
		write_reg(REG_MSG_ENABLE, 32'(me));
		write_reg(REG_CMD_ENABLE, 32'(ce));
		write_reg(REG_MSG_WINDOW, 32'(mw));
		write_reg(REG_CMD_WINDOW, 32'(cw));
		write_reg(REG_MAX_MSG_CHARS, 32'(chars));
		write_reg(REG_MAX_MSG_COUNT, 32'(mc));
		write_reg(REG_MAX_CMD_COUNT, 32'(cc));
		write_reg(REG_MAX_IDLE, 32'(idle));
	endtask

	function automatic logic [30:0] pick_chars();
		case ($urandom_range(3))
			0: return '0;
			1: return 31'h7FFF_FFFF;
			default: return 31'($urandom_range(0, 3000));
		endcase
	endfunction

	function automatic logic [19:0] pick_count();
		case ($urandom_range(3))
			0: return '0;
			1: return 20'hFFFFF;
			default: return 20'($urandom_range(0, 30));
		endcase
	endfunction

	function automatic void reg_row(logic [2:0] idx, logic [31:0] val);
		step_t s;
		s = '{1'b1, idx, val, OP_TICK, 1'b0, 1'b0, VERDICT_ACCEPT};
		script.push_back(s);
	endfunction

	function automatic void typed_row(logic [1:0] op, logic [15:0] len, logic ex,
		logic [1:0] want);
		step_t s;
		s = '{1'b0, REG_MSG_ENABLE, {16'd0, len}, op, ex, 1'b1, want};
		script.push_back(s);
	endfunction

	function automatic void model_row(logic [1:0] op, logic [15:0] len, logic ex);
		step_t s;
		s = '{1'b0, REG_MSG_ENABLE, {16'd0, len}, op, ex, 1'b0, VERDICT_ACCEPT};
		script.push_back(s);
	endfunction

	initial begin
		int    step_no;
		int    phase;
		step_t s;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		operation = OP_TICK;
		msg_length = '0;
		exempt = 1'b0;
		calm = 1'b0;

		msg_fill = 0;
		cmd_fill = 0;
		msg_head = 0;
		cmd_head = 0;
		size_sum = '0;
		msg_cnt_sum = '0;
		cmd_cnt_sum = '0;
		tick_cnt = '0;
		last_seen = '0;
		session_shut = 1'b0;
		msg_on = 1'b0;
		cmd_on = 1'b0;
		msg_win = '0;
		cmd_win = '0;
		chars_cap = '0;
		idle_cap = '0;
		msg_cap = '0;
		cmd_cap = '0;

		// out of reset: idle limit zero, first tick still passes
		typed_row(OP_TICK, 16'd0, 1'b0, VERDICT_ACCEPT);
		reg_row(REG_MAX_IDLE, 32'h7FFF_FFFF);
		// both windows disabled: everything accepted
		typed_row(OP_MSG, 16'hFFFF, 1'b0, VERDICT_ACCEPT);
		typed_row(OP_CMD, 16'd0, 1'b0, VERDICT_ACCEPT);
		typed_row(OP_OTHER, 16'd0, 1'b0, VERDICT_ACCEPT);
		// chat window longer than the store, tight limits
		reg_row(REG_MSG_ENABLE, 32'd1);
		reg_row(REG_MSG_WINDOW, 32'd31);
		reg_row(REG_MAX_MSG_CHARS, 32'd100);
		reg_row(REG_MAX_MSG_COUNT, 32'd2);
		typed_row(OP_MSG, 16'd0, 1'b0, VERDICT_ACCEPT);
		typed_row(OP_MSG, 16'd100, 1'b0, VERDICT_ACCEPT);
		typed_row(OP_MSG, 16'd1, 1'b0, VERDICT_FLOOD);
		typed_row(OP_TICK, 16'd0, 1'b0, VERDICT_ACCEPT);
		// command window of zero length, zero limit
		reg_row(REG_CMD_ENABLE, 32'd1);
		reg_row(REG_CMD_WINDOW, 32'd0);
		reg_row(REG_MAX_CMD_COUNT, 32'd0);
		typed_row(OP_CMD, 16'd0, 1'b1, VERDICT_ACCEPT);
		typed_row(OP_CMD, 16'd0, 1'b0, VERDICT_FLOOD);
		model_row(OP_TICK, 16'd0, 1'b0);
		model_row(OP_CMD, 16'd0, 1'b0);
		// shrink the chat window under its fill
		reg_row(REG_MSG_WINDOW, 32'd1);
		model_row(OP_TICK, 16'd0, 1'b0);
		model_row(OP_TICK, 16'd0, 1'b0);
		model_row(OP_MSG, 16'd0, 1'b0);
		// top count limits never flood
		reg_row(REG_MAX_CMD_COUNT, 32'hFFFFF);
		typed_row(OP_CMD, 16'd0, 1'b0, VERDICT_ACCEPT);
		reg_row(REG_MAX_MSG_CHARS, 32'h7FFF_FFFF);
		reg_row(REG_MAX_MSG_COUNT, 32'hFFFFF);
		typed_row(OP_MSG, 16'hFFFF, 1'b0, VERDICT_ACCEPT);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (step_no = 0; step_no < script.size(); step_no++) begin
			s = script[step_no];
			if (s.is_reg) begin
				drain_items();
				write_reg(s.reg_idx, s.value);
			end else begin
				offer_item(s.op, s.value[15:0], s.ex, s.typed, s.want);
			end
		end

		// idle limit stays far above the tick count until the closing part
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: load_limits(1'b1, 1'b1, 5'd16, 5'd16, pick_chars(), pick_count(),
					pick_count(), 31'h7FFF_FFFF);
				1: load_limits(1'b1, 1'b1, 5'd0, 5'd0, 31'($urandom_range(0, 3000)),
					20'($urandom_range(0, 20)), 20'($urandom_range(0, 20)),
					31'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF)));
				2: load_limits(1'b1, 1'b1, 5'd31, 5'd17, 31'h7FFF_FFFF, 20'hFFFFF,
					20'hFFFFF, 31'h7FFF_FFFF);
				3: load_limits(1'b0, 1'b0, 5'($urandom_range(0, 31)),
					5'($urandom_range(0, 31)), pick_chars(), pick_count(), pick_count(),
					31'h7FFF_FFFF);
				default: load_limits(1'($urandom_range(1)), 1'($urandom_range(1)),
					5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), pick_chars(),
					pick_count(), pick_count(),
					31'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF)));
			endcase
			calm = (phase == 5);
			repeat (PHASE_ITEMS) offer_random(30);
			calm = 1'b0;
		end

		// a run of full-length messages in one window
		load_limits(1'b1, 1'($urandom_range(1)), 5'd16, 5'($urandom_range(0, 31)),
			31'h7FFF_FFFF, 20'hFFFFF, pick_count(), 31'h7FFF_FFFF);
		calm = 1'b1;
		repeat (FLOOD_BURST) offer_item(OP_MSG, 16'hFFFF, 1'($urandom_range(1)), 1'b0,
			VERDICT_ACCEPT);
		repeat (20) offer_item(OP_TICK, 16'd0, 1'b0, 1'b0, VERDICT_ACCEPT);
		repeat (10) offer_random(30);
		calm = 1'b0;

		// small idle limit, then zero: the session closes and stays closed
		drain_items();
		write_reg(REG_MAX_IDLE, $urandom_range(2, 6));
		repeat (60) offer_random(45);
		drain_items();
		write_reg(REG_MAX_IDLE, 32'd0);
		repeat (40) offer_random(50);

		drain_items();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("sliding_window_flood_limiter verification clean");
		else
			$display("sliding_window_flood_limiter verification failed");
		$finish;
	end

endmodule
